// ----- rtl/tgsbc_pkg.sv -----
// Package: shared types and constants of the tile grid swept box collision block.
package tgsbc_pkg;

    localparam int COL_BITS  = 5;
    localparam int ROW_BITS  = 5;
    localparam int ADDR_BITS = COL_BITS + ROW_BITS;
    localparam int ID_BITS   = 8;
    localparam int POS_BITS  = 34;
    localparam int NUM_BITS  = 27;
    localparam int MAG_BITS  = 26;
    localparam int DEN_BITS  = 8;
    localparam int REG_BITS  = 20;
    localparam int CNT_BITS  = 5;

    localparam logic [1:0] CFG_CELL_W = 2'd0;
    localparam logic [1:0] CFG_CELL_H = 2'd1;
    localparam logic [1:0] CFG_COLS   = 2'd2;
    localparam logic [1:0] CFG_ROWS   = 2'd3;

    localparam logic [2:0] DIV_INC_X  = 3'd0;
    localparam logic [2:0] DIV_INC_Y  = 3'd1;
    localparam logic [2:0] DIV_COL_LO = 3'd2;
    localparam logic [2:0] DIV_ROW_LO = 3'd3;
    localparam logic [2:0] DIV_COL_HI = 3'd4;
    localparam logic [2:0] DIV_ROW_HI = 3'd5;

    localparam logic OP_WRITE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_REGION,
        S_MOVE_X,
        S_MOVE_Y,
        S_RD,
        S_E1,
        S_E2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [MAG_BITS-1:0]   dividend;
        logic [DEN_BITS-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                  en;
        logic [ADDR_BITS-1:0]  addr;
        logic [ID_BITS-1:0]    data;
    } t_wr_req;

endpackage

// ----- rtl/tile_grid_swept_box_collision.sv -----
// Top level: moves a box through a tile grid in sub-steps, pushing it out of solid tiles.
// After reset the block clears its 1024-entry tile store, one entry a cycle, and takes no
// transaction until the clear is done. A write transaction goes straight to the store. A move
// runs six divisions on the shared divider, then for each sub-step two scans of the region
// (one per axis, none if the region is empty), each cell visited being read through the
// single read port of the tile store.
module tile_grid_swept_box_collision (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_operation,
    input  logic [4:0]           i_cell_column,
    input  logic [4:0]           i_cell_row,
    input  logic [7:0]           i_cell_id,
    input  logic signed [23:0]   i_box_x,
    input  logic signed [23:0]   i_box_y,
    input  logic [15:0]          i_box_w,
    input  logic [15:0]          i_box_h,
    input  logic signed [23:0]   i_goal_x,
    input  logic signed [23:0]   i_goal_y,
    input  logic [7:0]           i_step_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [23:0]   o_final_x,
    output logic signed [23:0]   o_final_y
);
    localparam int PB = tgsbc_pkg::POS_BITS;
    localparam int NB = tgsbc_pkg::NUM_BITS;
    localparam int RB = tgsbc_pkg::REG_BITS;

    tgsbc_pkg::t_state r_state, n_state;

    logic [6:0] r_cell_w, r_cell_h;
    logic [5:0] r_cols, r_rows;

    logic                                  r_clearing;
    logic [tgsbc_pkg::ADDR_BITS-1:0]       r_clr_addr;

    logic signed [PB-1:0] r_px, r_py;
    logic [15:0]          r_w, r_h;
    logic signed [23:0]   r_gx, r_gy;
    logic [7:0]           r_steps, r_step;
    logic [6:0]           r_cw, r_ch;
    logic signed [NB-1:0] r_incx, r_incy;
    logic signed [RB-1:0] r_qcl, r_qrl, r_qch, r_qrh;
    logic [2:0]           r_div_idx;
    logic                 r_div_neg;
    logic [4:0]           r_col_lo, r_col_hi, r_row_lo, r_row_hi, r_c, r_r;
    logic                 r_empty, r_axis_x;
    logic signed [PB-1:0] r_cx, r_cy, r_left, r_right, r_top, r_bottom;

    tgsbc_pkg::t_div_req  div_req;
    logic                 div_busy, div_done;
    logic [tgsbc_pkg::MAG_BITS-1:0] div_quot;
    tgsbc_pkg::t_wr_req   wr_req;
    logic [tgsbc_pkg::ID_BITS-1:0]  rd_data;

    logic in_acc, out_free;
    logic signed [NB-1:0] num, num_abs;
    logic signed [NB-1:0] q_signed;
    logic signed [PB-1:0] cx_end, cy_end, ox, oy;
    logic signed [RB-1:0] clo, rlo, chi, rhi, col_max, row_max;
    logic last_c, last_r;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_clearing || (r_state != tgsbc_pkg::S_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    tgsbc_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_addr ({r_r, r_c}),
        .o_rd_data (rd_data)
    );

    tgsbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        wr_req.en   = r_clearing || (in_acc && i_operation == tgsbc_pkg::OP_WRITE);
        wr_req.addr = r_clearing ? r_clr_addr : {i_cell_row, i_cell_column};
        wr_req.data = r_clearing ? '0 : i_cell_id;
    end

    // divider operand select
    always_comb begin
        case (r_div_idx)
            tgsbc_pkg::DIV_INC_X:  num = NB'(r_gx) - NB'(r_px);
            tgsbc_pkg::DIV_INC_Y:  num = NB'(r_gy) - NB'(r_py);
            tgsbc_pkg::DIV_COL_LO:
                num = ((r_gx < r_px) ? NB'(r_gx) : NB'(r_px)) - NB'({1'b0, r_w});
            tgsbc_pkg::DIV_ROW_LO:
                num = ((r_gy < r_py) ? NB'(r_gy) : NB'(r_py)) - NB'({1'b0, r_h});
            tgsbc_pkg::DIV_COL_HI:
                num = ((NB'(r_gx) > NB'(r_px) + $signed(NB'({1'b0, r_w}))) ? NB'(r_gx)
                       : NB'(r_px) + $signed(NB'({1'b0, r_w}))) + NB'({1'b0, r_w});
            default:
                num = ((NB'(r_gy) > NB'(r_py) + $signed(NB'({1'b0, r_h}))) ? NB'(r_gy)
                       : NB'(r_py) + $signed(NB'({1'b0, r_h}))) + NB'({1'b0, r_h});
        endcase
        num_abs = num[NB-1] ? -num : num;
        div_req.start    = (r_state == tgsbc_pkg::S_DIV_GO);
        div_req.dividend = (r_div_idx == tgsbc_pkg::DIV_INC_X ||
                            r_div_idx == tgsbc_pkg::DIV_INC_Y)
                           ? num_abs[tgsbc_pkg::MAG_BITS-1:0]
                           : tgsbc_pkg::MAG_BITS'(num_abs[tgsbc_pkg::MAG_BITS-1:8]);
        if (r_div_idx == tgsbc_pkg::DIV_INC_X || r_div_idx == tgsbc_pkg::DIV_INC_Y) begin
            div_req.divisor = r_steps;
        end else if (r_div_idx == tgsbc_pkg::DIV_COL_LO ||
                     r_div_idx == tgsbc_pkg::DIV_COL_HI) begin
            div_req.divisor = {1'b0, r_cw};
        end else begin
            div_req.divisor = {1'b0, r_ch};
        end
        q_signed = r_div_neg ? -NB'({1'b0, div_quot}) : NB'({1'b0, div_quot});
    end

    always_comb begin
        col_max = RB'($signed({1'b0, ((r_cols > 6'd32) ? 6'd32 : r_cols)})) - RB'(1);
        row_max = RB'($signed({1'b0, ((r_rows > 6'd32) ? 6'd32 : r_rows)})) - RB'(1);
        clo = r_qcl[RB-1] ? '0 : r_qcl;
        rlo = r_qrl[RB-1] ? '0 : r_qrl;
        chi = (r_qch < col_max) ? r_qch : col_max;
        rhi = (r_qrh < row_max) ? r_qrh : row_max;
        cx_end = r_cx + $signed(PB'({r_cw, 8'd0}));
        cy_end = r_cy + $signed(PB'({r_ch, 8'd0}));
        ox     = r_right - r_left;
        oy     = r_bottom - r_top;
        last_c = (r_c == r_col_hi);
        last_r = (r_r == r_row_hi);
    end

    // next state
    always_comb begin
        logic brk;
        logic valid_ov;
        brk      = 1'b0;
        valid_ov = (r_left < r_right) && (r_top < r_bottom);
        n_state  = r_state;
        case (r_state)
            tgsbc_pkg::S_IDLE: begin
                if (in_acc && i_operation != tgsbc_pkg::OP_WRITE) begin
                    n_state = tgsbc_pkg::S_DIV_GO;
                end
            end
            tgsbc_pkg::S_DIV_GO:   n_state = tgsbc_pkg::S_DIV_WAIT;
            tgsbc_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_div_idx == tgsbc_pkg::DIV_ROW_HI)
                              ? tgsbc_pkg::S_REGION : tgsbc_pkg::S_DIV_GO;
                end
            end
            tgsbc_pkg::S_REGION:   n_state = tgsbc_pkg::S_MOVE_X;
            tgsbc_pkg::S_MOVE_X:   n_state = r_empty ? tgsbc_pkg::S_MOVE_Y : tgsbc_pkg::S_RD;
            tgsbc_pkg::S_MOVE_Y: begin
                if (!r_empty) begin
                    n_state = tgsbc_pkg::S_RD;
                end else begin
                    n_state = (r_step == r_steps - 1'b1)
                              ? tgsbc_pkg::S_DONE : tgsbc_pkg::S_MOVE_X;
                end
            end
            tgsbc_pkg::S_RD:       n_state = tgsbc_pkg::S_E1;
            tgsbc_pkg::S_E1,
            tgsbc_pkg::S_E2: begin
                if (r_state == tgsbc_pkg::S_E1 && rd_data != '0) begin
                    n_state = tgsbc_pkg::S_E2;
                end else begin
                    if (r_state == tgsbc_pkg::S_E2 && valid_ov) begin
                        brk = r_axis_x ? (ox < oy) : (oy < ox);
                    end
                    if ((brk || last_c) && last_r) begin
                        if (r_axis_x) begin
                            n_state = tgsbc_pkg::S_MOVE_Y;
                        end else begin
                            n_state = (r_step == r_steps - 1'b1)
                                      ? tgsbc_pkg::S_DONE : tgsbc_pkg::S_MOVE_X;
                        end
                    end else begin
                        n_state = tgsbc_pkg::S_RD;
                    end
                end
            end
            tgsbc_pkg::S_DONE:     if (out_free) n_state = tgsbc_pkg::S_IDLE;
            default:               n_state = tgsbc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgsbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_w   <= 7'd8;
            r_cell_h   <= 7'd8;
            r_cols     <= 6'd32;
            r_rows     <= 6'd32;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tgsbc_pkg::CFG_CELL_W: r_cell_w <= i_cfg_data;
                    tgsbc_pkg::CFG_CELL_H: r_cell_h <= i_cfg_data;
                    tgsbc_pkg::CFG_COLS:   r_cols   <= i_cfg_data[5:0];
                    tgsbc_pkg::CFG_ROWS:   r_rows   <= i_cfg_data[5:0];
                    default:               r_cols   <= r_cols;
                endcase
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == tgsbc_pkg::S_DONE && out_free) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            tgsbc_pkg::S_IDLE: begin
                r_px      <= PB'(i_box_x);
                r_py      <= PB'(i_box_y);
                r_w       <= i_box_w;
                r_h       <= i_box_h;
                r_gx      <= i_goal_x;
                r_gy      <= i_goal_y;
                r_steps   <= (i_step_count == '0) ? 8'd1 : i_step_count;
                r_cw      <= (r_cell_w == '0) ? 7'd1 : r_cell_w;
                r_ch      <= (r_cell_h == '0) ? 7'd1 : r_cell_h;
                r_div_idx <= tgsbc_pkg::DIV_INC_X;
            end
            tgsbc_pkg::S_DIV_GO: r_div_neg <= num[NB-1];
            tgsbc_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    case (r_div_idx)
                        tgsbc_pkg::DIV_INC_X:  r_incx <= q_signed;
                        tgsbc_pkg::DIV_INC_Y:  r_incy <= q_signed;
                        tgsbc_pkg::DIV_COL_LO: r_qcl  <= q_signed[RB-1:0];
                        tgsbc_pkg::DIV_ROW_LO: r_qrl  <= q_signed[RB-1:0];
                        tgsbc_pkg::DIV_COL_HI: r_qch  <= q_signed[RB-1:0];
                        default:               r_qrh  <= q_signed[RB-1:0];
                    endcase
                    r_div_idx <= r_div_idx + 1'b1;
                end
            end
            tgsbc_pkg::S_REGION: begin
                r_empty  <= (clo > chi) || (rlo > rhi);
                r_col_lo <= clo[4:0];
                r_col_hi <= chi[4:0];
                r_row_lo <= rlo[4:0];
                r_row_hi <= rhi[4:0];
                r_step   <= '0;
            end
            tgsbc_pkg::S_MOVE_X: begin
                r_px     <= r_px + PB'(r_incx);
                r_axis_x <= 1'b1;
                r_r      <= r_row_lo;
                r_c      <= r_col_lo;
            end
            tgsbc_pkg::S_MOVE_Y: begin
                r_py     <= r_py + PB'(r_incy);
                r_axis_x <= 1'b0;
                r_r      <= r_row_lo;
                r_c      <= r_col_lo;
                if (r_empty) r_step <= r_step + 1'b1;
            end
            tgsbc_pkg::S_RD: begin
                r_cx <= PB'({12'(r_c) * 12'(r_cw), 8'd0});
                r_cy <= PB'({12'(r_r) * 12'(r_ch), 8'd0});
            end
            tgsbc_pkg::S_E1,
            tgsbc_pkg::S_E2: begin
                if (r_state == tgsbc_pkg::S_E1 && rd_data != '0) begin
                    r_left   <= (r_cx > r_px) ? r_cx : r_px;
                    r_right  <= (cx_end < r_px + $signed(PB'({1'b0, r_w}))) ? cx_end
                                : r_px + $signed(PB'({1'b0, r_w}));
                    r_top    <= (r_cy > r_py) ? r_cy : r_py;
                    r_bottom <= (cy_end < r_py + $signed(PB'({1'b0, r_h}))) ? cy_end
                                : r_py + $signed(PB'({1'b0, r_h}));
                end else begin
                    logic brk_d;
                    brk_d = 1'b0;
                    if (r_state == tgsbc_pkg::S_E2 && (r_left < r_right) && (r_top < r_bottom))
                    begin
                        if (r_axis_x && ox < oy) begin
                            brk_d = 1'b1;
                            r_px  <= (r_px < r_cx) ? r_px - ox : r_px + ox;
                        end else if (!r_axis_x && oy < ox) begin
                            brk_d = 1'b1;
                            r_py  <= (r_py < r_cy) ? r_py - oy : r_py + oy;
                        end
                    end
                    if (brk_d || last_c) begin
                        r_c <= r_col_lo;
                        if (last_r) begin
                            if (!r_axis_x) r_step <= r_step + 1'b1;
                        end else begin
                            r_r <= r_r + 1'b1;
                        end
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
            end
            tgsbc_pkg::S_DONE: begin
                if (out_free) begin
                    o_final_x <= (r_px > PB'(24'sh7FFFFF)) ? 24'sh7FFFFF
                               : (r_px < -PB'(25'sh0800000)) ? 24'sh800000 : r_px[23:0];
                    o_final_y <= (r_py > PB'(24'sh7FFFFF)) ? 24'sh7FFFFF
                               : (r_py < -PB'(25'sh0800000)) ? 24'sh800000 : r_py[23:0];
                end
            end
            default: r_step <= r_step;
        endcase
    end

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> o_in_stall)
        else $error("transaction taken during store clear");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tgsbc_pkg::S_RD || r_state == tgsbc_pkg::S_E1 ||
         r_state == tgsbc_pkg::S_E2) |-> (r_r <= r_row_hi && r_c <= r_col_hi && !r_empty))
        else $error("scan outside region");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider restarted while busy");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == tgsbc_pkg::S_DIV_WAIT)
        else $error("divider result without waiting state");
endmodule

// ----- rtl/tgsbc_store.sv -----
// Tile store: one write port, one registered read port.
module tgsbc_store (
    input  logic                             i_clk,
    input  tgsbc_pkg::t_wr_req               i_wr,
    input  logic [tgsbc_pkg::ADDR_BITS-1:0]  i_rd_addr,
    output logic [tgsbc_pkg::ID_BITS-1:0]    o_rd_data
);
    logic [tgsbc_pkg::ID_BITS-1:0] r_mem [0:(1 << tgsbc_pkg::ADDR_BITS)-1];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ----- rtl/tgsbc_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
module tgsbc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tgsbc_pkg::t_div_req             i_req,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [tgsbc_pkg::MAG_BITS-1:0]  o_quot
);
    logic [tgsbc_pkg::MAG_BITS-1:0] r_quo;
    logic [tgsbc_pkg::DEN_BITS-1:0] r_rem;
    logic [tgsbc_pkg::DEN_BITS-1:0] r_den;
    logic [tgsbc_pkg::CNT_BITS:0]   r_cnt;
    logic                           r_done;
    logic [tgsbc_pkg::DEN_BITS:0]   trial;
    logic                           fits;

    assign trial  = {r_rem, r_quo[tgsbc_pkg::MAG_BITS-1]};
    assign fits   = trial >= {1'b0, r_den};
    assign o_busy = r_cnt != '0;
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= (tgsbc_pkg::CNT_BITS+1)'(tgsbc_pkg::MAG_BITS);
            end else if (o_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (o_busy) begin
            r_rem <= fits ? tgsbc_pkg::DEN_BITS'(trial - {1'b0, r_den})
                          : trial[tgsbc_pkg::DEN_BITS-1:0];
            r_quo <= {r_quo[tgsbc_pkg::MAG_BITS-2:0], fits};
        end
    end
endmodule
